// ----- design/can_bt_pkg.sv -----
`default_nettype none

package can_bt_pkg;

    // Shared divider geometry: dividend bits, divisor bits, step counter bits.
    localparam int unsigned DIV_DW = 50;
    localparam int unsigned DIV_VW = 28;
    localparam int unsigned DIV_SW = 5;

    // Divider step counts (two quotient bits per step) for each kind of division.
    localparam logic [DIV_SW-1:0] STEPS_RATE  = 5'd14;
    localparam logic [DIV_SW-1:0] STEPS_POINT = 5'd19;
    localparam logic [DIV_SW-1:0] STEPS_QPS   = 5'd25;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_NOM_LIMIT     = 3'd0;
    localparam logic [2:0] REG_NOM_SEG_MIN   = 3'd1;
    localparam logic [2:0] REG_NOM_SEG1_MAX  = 3'd2;
    localparam logic [2:0] REG_NOM_SEG2_MAX  = 3'd3;
    localparam logic [2:0] REG_DATA_LIMIT    = 3'd4;
    localparam logic [2:0] REG_DATA_SEG_MIN  = 3'd5;
    localparam logic [2:0] REG_DATA_SEG1_MAX = 3'd6;
    localparam logic [2:0] REG_DATA_SEG2_MAX = 3'd7;

    // Result status codes.
    localparam logic [1:0] ST_NOM_FAIL  = 2'd0;
    localparam logic [1:0] ST_DATA_FAIL = 2'd1;
    localparam logic [1:0] ST_BOTH      = 2'd2;

    // Arithmetic constants.
    localparam logic [10:0] NOM_LIMIT_CAP  = 11'd1024;
    localparam logic [10:0] DATA_LIMIT_CAP = 11'd64;
    localparam logic [39:0] PS_PER_SECOND  = 40'd1000000000000;
    localparam logic [DIV_VW-1:0] PERMILLE = 28'd1000;

    typedef struct packed {
        logic [10:0] nom_limit;
        logic [8:0]  nom_seg_min;
        logic [8:0]  nom_seg1_max;
        logic [7:0]  nom_seg2_max;
        logic [6:0]  data_limit;
        logic [5:0]  data_seg_min;
        logic [5:0]  data_seg1_max;
        logic [4:0]  data_seg2_max;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
        logic [DIV_SW-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
        logic [DIV_VW-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- design/can_fd_bit_timing_search_core.sv -----
`default_nettype none

// CAN FD bit timing search.
// A request is a transfer on start while busy is low; it carries the controller
// clock, the nominal and data bit rates and their sample points. Busy stays high
// while the request is searched, and exactly one result follows, held on the
// result ports for one cycle with o_valid high. The receiver cannot stall; a new
// request may be given in the cycle that o_valid is high.
// Prescalers are tried from one upward, first for the nominal phase and then,
// if that succeeds, for the data phase. Each trial uses the 14-step shared
// divider (two quotient bits per cycle) to check whether the clock divides
// evenly. An even division adds the sample point division, and a nominal hit
// adds the quantum division.
// Rates so high that the clock cannot hold one quantum end a phase early.
// The registers are to be written through the APB port only while idle; the
// block itself does not enforce this. Reset returns them to their defaults,
// drops any search in progress and clears o_valid.

module can_fd_bit_timing_search_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [27:0] i_clock_hz,
    input  wire logic [19:0] i_nominal_rate_bps,
    input  wire logic [9:0]  i_nominal_point_permille,
    input  wire logic [23:0] i_data_rate_bps,
    input  wire logic [9:0]  i_data_point_permille,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [9:0]       o_nominal_brp,
    output logic [8:0]       o_nominal_seg1,
    output logic [7:0]       o_nominal_seg2,
    output logic [7:0]       o_nominal_jump,
    output logic [31:0]      o_quantum_ps,
    output logic [5:0]       o_data_brp,
    output logic [5:0]       o_data_seg1,
    output logic [4:0]       o_data_seg2,
    output logic [4:0]       o_data_jump
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TRY   = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_WAIT1 = 4'd3;
    localparam logic [3:0] S_DIV2  = 4'd4;
    localparam logic [3:0] S_WAIT2 = 4'd5;
    localparam logic [3:0] S_CHECK = 4'd6;
    localparam logic [3:0] S_QPS   = 4'd7;
    localparam logic [3:0] S_WAITQ = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    can_bt_pkg::t_cfg     cfg;
    can_bt_pkg::t_div_req div_req;
    can_bt_pkg::t_div_rsp div_rsp;

    logic [3:0]  r_state;
    logic        r_phase;
    logic        r_valid;
    logic [10:0] r_p;
    logic [34:0] r_div;
    logic [37:0] r_prod;
    logic [27:0] r_q;
    logic [28:0] r_a;

    logic [27:0] r_clock;
    logic [19:0] r_nrate;
    logic [9:0]  r_npoint;
    logic [23:0] r_drate;
    logic [9:0]  r_dpoint;

    logic [1:0]  r_status;
    logic [9:0]  r_nbrp;
    logic [8:0]  r_ns1;
    logic [7:0]  r_ns2;
    logic [31:0] r_qps;
    logic [5:0]  r_dbrp;
    logic [5:0]  r_ds1;
    logic [4:0]  r_ds2;

    logic [23:0] cur_rate;
    logic [9:0]  cur_point;
    logic [10:0] nom_lim, data_lim, cur_limit;
    logic [8:0]  cur_seg_min, cur_s1_max;
    logic [7:0]  cur_s2_max;
    logic [28:0] s1, s2;
    logic        seg_ok;
    logic        too_fast;
    logic        phase_end;
    logic [49:0] qps_num;

    can_bt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    can_bt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Per-phase operands and limits.
    always_comb begin
        nom_lim  = (cfg.nom_limit > can_bt_pkg::NOM_LIMIT_CAP) ?
                   can_bt_pkg::NOM_LIMIT_CAP : cfg.nom_limit;
        data_lim = ({4'b0, cfg.data_limit} > can_bt_pkg::DATA_LIMIT_CAP) ?
                   can_bt_pkg::DATA_LIMIT_CAP : {4'b0, cfg.data_limit};
        if (r_phase) begin
            cur_rate    = r_drate;
            cur_point   = r_dpoint;
            cur_limit   = data_lim;
            cur_seg_min = {3'b0, cfg.data_seg_min};
            cur_s1_max  = {3'b0, cfg.data_seg1_max};
            cur_s2_max  = {3'b0, cfg.data_seg2_max};
        end else begin
            cur_rate    = {4'b0, r_nrate};
            cur_point   = r_npoint;
            cur_limit   = nom_lim;
            cur_seg_min = cfg.nom_seg_min;
            cur_s1_max  = cfg.nom_seg1_max;
            cur_s2_max  = cfg.nom_seg2_max;
        end
    end

    // Segment check for a prescaler whose quanta per bit divide evenly.
    always_comb begin
        s1     = r_a - 29'd1;
        s2     = {1'b0, r_q} - r_a;
        seg_ok = (r_a != 29'd0) && (r_a <= {1'b0, r_q}) &&
                 (s1 >= {20'b0, cur_seg_min}) && (s1 <= {20'b0, cur_s1_max}) &&
                 (s2 >= {20'b0, cur_seg_min}) && (s2 <= {21'b0, cur_s2_max});
    end

    // Once p * rate exceeds the clock, no larger prescaler gives a quantum.
    assign too_fast  = (r_div > {7'b0, r_clock});
    assign phase_end = (cur_rate == 24'd0) || (r_p >= cur_limit);
    assign qps_num   = 50'(r_p[9:0]) * 50'(can_bt_pkg::PS_PER_SECOND);

    // Divider commands issued by the sequencer.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = {r_clock, 22'b0};
        div_req.divisor  = r_div[27:0];
        div_req.steps    = can_bt_pkg::STEPS_RATE;
        unique case (r_state)
            S_DIV1: begin
                div_req.start = !too_fast;
            end
            S_DIV2: begin
                div_req.start    = 1'b1;
                div_req.dividend = {r_prod, 12'b0};
                div_req.divisor  = can_bt_pkg::PERMILLE;
                div_req.steps    = can_bt_pkg::STEPS_POINT;
            end
            S_QPS: begin
                div_req.start    = 1'b1;
                div_req.dividend = qps_num;
                div_req.divisor  = r_clock;
                div_req.steps    = can_bt_pkg::STEPS_QPS;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Search sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_clock  <= i_clock_hz;
                        r_nrate  <= i_nominal_rate_bps;
                        r_npoint <= i_nominal_point_permille;
                        r_drate  <= i_data_rate_bps;
                        r_dpoint <= i_data_point_permille;
                        r_status <= can_bt_pkg::ST_NOM_FAIL;
                        r_nbrp   <= '0;
                        r_ns1    <= '0;
                        r_ns2    <= '0;
                        r_qps    <= '0;
                        r_dbrp   <= '0;
                        r_ds1    <= '0;
                        r_ds2    <= '0;
                        r_phase  <= 1'b0;
                        r_p      <= 11'd1;
                        r_state  <= S_TRY;
                    end
                end
                S_TRY: begin
                    if (phase_end) begin
                        r_status <= r_phase ? can_bt_pkg::ST_DATA_FAIL
                                            : can_bt_pkg::ST_NOM_FAIL;
                        r_state  <= S_DONE;
                    end else begin
                        r_div   <= 35'(r_p) * 35'(cur_rate);
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (too_fast) begin
                        r_status <= r_phase ? can_bt_pkg::ST_DATA_FAIL
                                            : can_bt_pkg::ST_NOM_FAIL;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_WAIT1;
                    end
                end
                S_WAIT1: begin
                    if (div_rsp.done) begin
                        if (div_rsp.remainder != '0) begin
                            r_p     <= r_p + 11'd1;
                            r_state <= S_TRY;
                        end else begin
                            r_q     <= div_rsp.quotient[27:0];
                            r_prod  <= 38'(div_rsp.quotient[27:0]) * 38'(cur_point);
                            r_state <= S_DIV2;
                        end
                    end
                end
                S_DIV2: begin
                    r_state <= S_WAIT2;
                end
                S_WAIT2: begin
                    if (div_rsp.done) begin
                        r_a     <= div_rsp.quotient[28:0];
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!seg_ok) begin
                        r_p     <= r_p + 11'd1;
                        r_state <= S_TRY;
                    end else if (!r_phase) begin
                        r_nbrp  <= r_p[9:0];
                        r_ns1   <= s1[8:0];
                        r_ns2   <= s2[7:0];
                        r_state <= S_QPS;
                    end else begin
                        r_dbrp   <= r_p[5:0];
                        r_ds1    <= s1[5:0];
                        r_ds2    <= s2[4:0];
                        r_status <= can_bt_pkg::ST_BOTH;
                        r_state  <= S_DONE;
                    end
                end
                S_QPS: begin
                    r_state <= S_WAITQ;
                end
                S_WAITQ: begin
                    if (div_rsp.done) begin
                        r_qps   <= (div_rsp.quotient[49:32] != '0) ? 32'hFFFF_FFFF
                                                                    : div_rsp.quotient[31:0];
                        r_phase <= 1'b1;
                        r_p     <= 11'd1;
                        r_state <= S_TRY;
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result ports.
    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_nominal_brp  = r_nbrp;
    assign o_nominal_seg1 = r_ns1;
    assign o_nominal_seg2 = r_ns2;
    assign o_nominal_jump = r_ns2;
    assign o_quantum_ps   = r_qps;
    assign o_data_brp     = r_dbrp;
    assign o_data_seg1    = r_ds1;
    assign o_data_seg2    = r_ds2;
    assign o_data_jump    = r_ds2;

`ifndef SYNTHESIS
    // A result only appears once the search has finished.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted request starts a search.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but search not started");

    // One result per request, never two strobes in a row.
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe repeated");

    // A failed nominal search reports no timing at all.
    a_nom_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == can_bt_pkg::ST_NOM_FAIL)) |->
        ((o_nominal_brp == 10'd0) && (o_quantum_ps == 32'd0) && (o_data_brp == 6'd0)))
        else $error("nominal failure with nonzero fields");
`endif

endmodule

`default_nettype wire

// ----- design/can_bt_regs.sv -----
`default_nettype none

module can_bt_regs (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output can_bt_pkg::t_cfg       o_cfg
);

    can_bt_pkg::t_cfg r_cfg;
    logic [2:0]       idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // A write transfer lands in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nom_limit     <= 11'd512;
            r_cfg.nom_seg_min   <= 9'd1;
            r_cfg.nom_seg1_max  <= 9'd256;
            r_cfg.nom_seg2_max  <= 8'd128;
            r_cfg.data_limit    <= 7'd32;
            r_cfg.data_seg_min  <= 6'd1;
            r_cfg.data_seg1_max <= 6'd32;
            r_cfg.data_seg2_max <= 5'd16;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                can_bt_pkg::REG_NOM_LIMIT:     r_cfg.nom_limit     <= pwdata[10:0];
                can_bt_pkg::REG_NOM_SEG_MIN:   r_cfg.nom_seg_min   <= pwdata[8:0];
                can_bt_pkg::REG_NOM_SEG1_MAX:  r_cfg.nom_seg1_max  <= pwdata[8:0];
                can_bt_pkg::REG_NOM_SEG2_MAX:  r_cfg.nom_seg2_max  <= pwdata[7:0];
                can_bt_pkg::REG_DATA_LIMIT:    r_cfg.data_limit    <= pwdata[6:0];
                can_bt_pkg::REG_DATA_SEG_MIN:  r_cfg.data_seg_min  <= pwdata[5:0];
                can_bt_pkg::REG_DATA_SEG1_MAX: r_cfg.data_seg1_max <= pwdata[5:0];
                can_bt_pkg::REG_DATA_SEG2_MAX: r_cfg.data_seg2_max <= pwdata[4:0];
            endcase
        end
    end

    // Read data returns the addressed register, zero extended.
    always_comb begin
        unique case (idx)
            can_bt_pkg::REG_NOM_LIMIT:     prdata = {21'b0, r_cfg.nom_limit};
            can_bt_pkg::REG_NOM_SEG_MIN:   prdata = {23'b0, r_cfg.nom_seg_min};
            can_bt_pkg::REG_NOM_SEG1_MAX:  prdata = {23'b0, r_cfg.nom_seg1_max};
            can_bt_pkg::REG_NOM_SEG2_MAX:  prdata = {24'b0, r_cfg.nom_seg2_max};
            can_bt_pkg::REG_DATA_LIMIT:    prdata = {25'b0, r_cfg.data_limit};
            can_bt_pkg::REG_DATA_SEG_MIN:  prdata = {26'b0, r_cfg.data_seg_min};
            can_bt_pkg::REG_DATA_SEG1_MAX: prdata = {26'b0, r_cfg.data_seg1_max};
            can_bt_pkg::REG_DATA_SEG2_MAX: prdata = {27'b0, r_cfg.data_seg2_max};
        endcase
    end

endmodule

`default_nettype wire

// ----- design/can_bt_div.sv -----
`default_nettype none

module can_bt_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire can_bt_pkg::t_div_req i_req,
    output can_bt_pkg::t_div_rsp      o_rsp
);

    localparam int unsigned DW = can_bt_pkg::DIV_DW;
    localparam int unsigned VW = can_bt_pkg::DIV_VW;
    localparam int unsigned SW = can_bt_pkg::DIV_SW;

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_count;
    logic [DW-1:0] r_work;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_divisor;

    logic [VW:0]   t1, t2, d1, d2;
    logic [VW-1:0] m1, m2;
    logic          b1, b2;

    // Two restoring subtract steps per cycle; the dividend is left aligned in the
    // work register and quotient bits shift in from the bottom.
    always_comb begin
        t1 = {r_rem, r_work[DW-1]};
        d1 = t1 - {1'b0, r_divisor};
        b1 = (t1 >= {1'b0, r_divisor});
        m1 = b1 ? d1[VW-1:0] : t1[VW-1:0];
        t2 = {m1, r_work[DW-2]};
        d2 = t2 - {1'b0, r_divisor};
        b2 = (t2 >= {1'b0, r_divisor});
        m2 = b2 ? d2[VW-1:0] : t2[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_count   <= i_req.steps;
                r_work    <= i_req.dividend;
                r_rem     <= '0;
                r_divisor <= i_req.divisor;
            end else if (r_busy) begin
                r_work  <= {r_work[DW-3:0], b1, b2};
                r_rem   <= m2;
                r_count <= r_count - {{(SW-1){1'b0}}, 1'b1};
                if (r_count == {{(SW-1){1'b0}}, 1'b1}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_work;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

// ----- tb/can_fd_bit_timing_search_core_tb.sv -----
module can_fd_bit_timing_search_core_tb;

    localparam int unsigned CYCLE_LIMIT = 12000000;
    localparam int unsigned DRAIN_CYCLES = 200;

    // One search request as it is put on the input ports.
    typedef struct packed {
        logic [27:0] clock_hz;
        logic [19:0] nom_rate;
        logic [9:0]  nom_point;
        logic [23:0] data_rate;
        logic [9:0]  data_point;
    } t_timing_request;

    // One search result, in the order of the result ports.
    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  nom_brp;
        logic [8:0]  nom_seg1;
        logic [7:0]  nom_seg2;
        logic [7:0]  nom_jump;
        logic [31:0] quantum_ps;
        logic [5:0]  data_brp;
        logic [5:0]  data_seg1;
        logic [4:0]  data_seg2;
        logic [4:0]  data_jump;
    } t_timing_result;

    // Scoreboard: keeps its own register copy, computes the timing for each
    // accepted request and compares results against the oldest expectation.
    class timing_scoreboard;
        can_bt_pkg::t_cfg cfg;
        t_timing_result expected_timings[$];
        int errors;

        function new();
            cfg.nom_limit     = 11'd512;
            cfg.nom_seg_min   = 9'd1;
            cfg.nom_seg1_max  = 9'd256;
            cfg.nom_seg2_max  = 8'd128;
            cfg.data_limit    = 7'd32;
            cfg.data_seg_min  = 6'd1;
            cfg.data_seg1_max = 6'd32;
            cfg.data_seg2_max = 5'd16;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            unique case (idx)
                can_bt_pkg::REG_NOM_LIMIT:     cfg.nom_limit     = value[10:0];
                can_bt_pkg::REG_NOM_SEG_MIN:   cfg.nom_seg_min   = value[8:0];
                can_bt_pkg::REG_NOM_SEG1_MAX:  cfg.nom_seg1_max  = value[8:0];
                can_bt_pkg::REG_NOM_SEG2_MAX:  cfg.nom_seg2_max  = value[7:0];
                can_bt_pkg::REG_DATA_LIMIT:    cfg.data_limit    = value[6:0];
                can_bt_pkg::REG_DATA_SEG_MIN:  cfg.data_seg_min  = value[5:0];
                can_bt_pkg::REG_DATA_SEG1_MAX: cfg.data_seg1_max = value[5:0];
                can_bt_pkg::REG_DATA_SEG2_MAX: cfg.data_seg2_max = value[4:0];
            endcase
        endfunction

        // Tries prescalers from one upward and returns the first that gives
        // whole quanta per bit and segments within their bounds.
        function bit find_prescaler(logic [63:0] clk_hz, logic [63:0] rate,
                                    logic [63:0] point, logic [63:0] limit,
                                    logic [63:0] cap, logic [63:0] seg_min,
                                    logic [63:0] seg1_max, logic [63:0] seg2_max,
                                    output logic [63:0] brp, output logic [63:0] seg1,
                                    output logic [63:0] seg2);
            logic [63:0] lim, p, div, q, a, s1, s2;
            bit found;
            found = 1'b0;
            brp = '0;
            seg1 = '0;
            seg2 = '0;
            lim = (limit > cap) ? cap : limit;
            if (rate == 0) begin
                return 1'b0;
            end
            p = 1;
            while (p < lim && !found) begin
                div = p * rate;
                if (clk_hz % div == 0) begin
                    q = clk_hz / div;
                    a = (q * point) / 64'(can_bt_pkg::PERMILLE);
                    // A zero sample offset or one past the bit end has no valid split.
                    if (a != 0 && a <= q) begin
                        s1 = a - 1;
                        s2 = q - a;
                        if (s1 >= seg_min && s1 <= seg1_max &&
                            s2 >= seg_min && s2 <= seg2_max) begin
                            found = 1'b1;
                            brp = p;
                            seg1 = s1;
                            seg2 = s2;
                        end
                    end
                end
                p = p + 1;
            end
            return found;
        endfunction

        function t_timing_result predict_timing(t_timing_request r);
            t_timing_result res;
            logic [63:0] brp, s1, s2, qps;
            res = '0;
            res.status = can_bt_pkg::ST_NOM_FAIL;
            if (find_prescaler(64'(r.clock_hz), 64'(r.nom_rate), 64'(r.nom_point),
                               64'(cfg.nom_limit), 64'(can_bt_pkg::NOM_LIMIT_CAP),
                               64'(cfg.nom_seg_min), 64'(cfg.nom_seg1_max),
                               64'(cfg.nom_seg2_max), brp, s1, s2)) begin
                res.status   = can_bt_pkg::ST_DATA_FAIL;
                res.nom_brp  = brp[9:0];
                res.nom_seg1 = s1[8:0];
                res.nom_seg2 = s2[7:0];
                res.nom_jump = s2[7:0];
                if (r.clock_hz != 0) begin
                    qps = (brp * 64'(can_bt_pkg::PS_PER_SECOND)) / 64'(r.clock_hz);
                    res.quantum_ps = (qps > 64'hFFFFFFFF) ? 32'hFFFFFFFF : qps[31:0];
                end
                // The data phase is searched only after a nominal hit.
                if (find_prescaler(64'(r.clock_hz), 64'(r.data_rate), 64'(r.data_point),
                                   64'(cfg.data_limit), 64'(can_bt_pkg::DATA_LIMIT_CAP),
                                   64'(cfg.data_seg_min), 64'(cfg.data_seg1_max),
                                   64'(cfg.data_seg2_max), brp, s1, s2)) begin
                    res.status    = can_bt_pkg::ST_BOTH;
                    res.data_brp  = brp[5:0];
                    res.data_seg1 = s1[5:0];
                    res.data_seg2 = s2[4:0];
                    res.data_jump = s2[4:0];
                end
            end
            return res;
        endfunction

        function void note_request(t_timing_request r);
            expected_timings = {expected_timings, predict_timing(r)};
        endfunction

        function int pending();
            return expected_timings.size();
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
            end
        endfunction

        function void check_result(t_timing_result act);
            t_timing_result exp;
            if (expected_timings.size() == 0) begin
                errors++;
                $display("%0t: result with no request pending, expected none, actual status %0d",
                         $time, act.status);
                return;
            end
            exp = expected_timings.pop_front();
            compare_field("status", 32'(exp.status), 32'(act.status));
            compare_field("nominal_brp", 32'(exp.nom_brp), 32'(act.nom_brp));
            compare_field("nominal_seg1", 32'(exp.nom_seg1), 32'(act.nom_seg1));
            compare_field("nominal_seg2", 32'(exp.nom_seg2), 32'(act.nom_seg2));
            compare_field("nominal_jump", 32'(exp.nom_jump), 32'(act.nom_jump));
            compare_field("quantum_ps", exp.quantum_ps, act.quantum_ps);
            compare_field("data_brp", 32'(exp.data_brp), 32'(act.data_brp));
            compare_field("data_seg1", 32'(exp.data_seg1), 32'(act.data_seg1));
            compare_field("data_seg2", 32'(exp.data_seg2), 32'(act.data_seg2));
            compare_field("data_jump", 32'(exp.data_jump), 32'(act.data_jump));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [27:0] i_clock_hz;
    logic [19:0] i_nominal_rate_bps;
    logic [9:0]  i_nominal_point_permille;
    logic [23:0] i_data_rate_bps;
    logic [9:0]  i_data_point_permille;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [9:0]  o_nominal_brp;
    logic [8:0]  o_nominal_seg1;
    logic [7:0]  o_nominal_seg2;
    logic [7:0]  o_nominal_jump;
    logic [31:0] o_quantum_ps;
    logic [5:0]  o_data_brp;
    logic [5:0]  o_data_seg1;
    logic [4:0]  o_data_seg2;
    logic [4:0]  o_data_jump;

    timing_scoreboard sb;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;

    can_fd_bit_timing_search_core uut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .psel                     (psel),
        .penable                  (penable),
        .pwrite                   (pwrite),
        .paddr                    (paddr),
        .pwdata                   (pwdata),
        .prdata                   (prdata),
        .pready                   (pready),
        .start                    (start),
        .busy                     (busy),
        .i_clock_hz               (i_clock_hz),
        .i_nominal_rate_bps       (i_nominal_rate_bps),
        .i_nominal_point_permille (i_nominal_point_permille),
        .i_data_rate_bps          (i_data_rate_bps),
        .i_data_point_permille    (i_data_point_permille),
        .o_valid                  (o_valid),
        .o_status                 (o_status),
        .o_nominal_brp            (o_nominal_brp),
        .o_nominal_seg1           (o_nominal_seg1),
        .o_nominal_seg2           (o_nominal_seg2),
        .o_nominal_jump           (o_nominal_jump),
        .o_quantum_ps             (o_quantum_ps),
        .o_data_brp               (o_data_brp),
        .o_data_seg1              (o_data_seg1),
        .o_data_seg2              (o_data_seg2),
        .o_data_jump              (o_data_jump)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Every strobed result is a transfer; it is checked with pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            sb.check_result({o_status, o_nominal_brp, o_nominal_seg1, o_nominal_seg2,
                             o_nominal_jump, o_quantum_ps, o_data_brp, o_data_seg1,
                             o_data_seg2, o_data_jump});
        end
    end

    // Watchdog against a hung search.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // One register write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_reg(idx, value);
    endtask

    task automatic configure(input int unsigned nl, input int unsigned nmin,
                             input int unsigned n1, input int unsigned n2,
                             input int unsigned dl, input int unsigned dmin,
                             input int unsigned d1, input int unsigned d2);
        apb_write(can_bt_pkg::REG_NOM_LIMIT, nl);
        apb_write(can_bt_pkg::REG_NOM_SEG_MIN, nmin);
        apb_write(can_bt_pkg::REG_NOM_SEG1_MAX, n1);
        apb_write(can_bt_pkg::REG_NOM_SEG2_MAX, n2);
        apb_write(can_bt_pkg::REG_DATA_LIMIT, dl);
        apb_write(can_bt_pkg::REG_DATA_SEG_MIN, dmin);
        apb_write(can_bt_pkg::REG_DATA_SEG1_MAX, d1);
        apb_write(can_bt_pkg::REG_DATA_SEG2_MAX, d2);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sender works in bursts; between bursts start drops for a random gap.
    task automatic send_request(input t_timing_request r);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat (($urandom_range(0, 2) == 0) ? $urandom_range(100, 2500)
                                                : $urandom_range(1, 20)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left = burst_left - 1;
        start                    <= 1'b1;
        i_clock_hz               <= r.clock_hz;
        i_nominal_rate_bps       <= r.nom_rate;
        i_nominal_point_permille <= r.nom_point;
        i_data_rate_bps          <= r.data_rate;
        i_data_point_permille    <= r.data_point;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(r);
    endtask

    // Drop start and wait until every expected result has come back.
    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    function automatic t_timing_request make_request(int unsigned clk_hz, int unsigned nr,
                                                     int unsigned np, int unsigned dr,
                                                     int unsigned dp);
        t_timing_request r;
        r.clock_hz   = 28'(clk_hz);
        r.nom_rate   = 20'(nr);
        r.nom_point  = 10'(np);
        r.data_rate  = 24'(dr);
        r.data_point = 10'(dp);
        return r;
    endfunction

    // Mostly picks from the common part of a range, sometimes from all of it.
    function automatic int unsigned skewed(int unsigned lo, int unsigned hi,
                                           int unsigned common_lo, int unsigned common_hi);
        if ($urandom_range(0, 4) == 0) begin
            return $urandom_range(lo, hi);
        end
        return $urandom_range(common_lo, common_hi);
    endfunction

    // Builds a clock that divides evenly for both phases at small prescalers.
    function automatic t_timing_request wellformed_request();
        t_timing_request r;
        int unsigned nl, dl, pn, qn, pd, qd, span, m_max, lim_tmp, m;
        nl = (sb.cfg.nom_limit > can_bt_pkg::NOM_LIMIT_CAP) ? can_bt_pkg::NOM_LIMIT_CAP
                                                            : sb.cfg.nom_limit;
        dl = ({4'b0, sb.cfg.data_limit} > can_bt_pkg::DATA_LIMIT_CAP) ?
             can_bt_pkg::DATA_LIMIT_CAP : {4'b0, sb.cfg.data_limit};
        pn = $urandom_range(1, (nl > 17) ? 16 : ((nl > 1) ? nl - 1 : 1));
        pd = $urandom_range(1, (dl > 9) ? 8 : ((dl > 1) ? dl - 1 : 1));
        qn = $urandom_range(4, 60);
        qd = $urandom_range(3, 40);
        span = pn * qn * pd * qd;
        m_max = 32'h0FFFFFFF / span;
        lim_tmp = 32'h000FFFFF / (pd * qd);
        if (lim_tmp < m_max) m_max = lim_tmp;
        lim_tmp = 32'h00FFFFFF / (pn * qn);
        if (lim_tmp < m_max) m_max = lim_tmp;
        m = $urandom_range(1, m_max);
        r.clock_hz   = 28'(m * span);
        r.nom_rate   = 20'(m * pd * qd);
        r.data_rate  = 24'(m * pn * qn);
        r.nom_point  = 10'(skewed(0, 1023, 500, 950));
        r.data_point = 10'(skewed(0, 1023, 500, 950));
        return r;
    endfunction

    // Mix of well-formed requests, slightly broken ones and raw noise.
    function automatic t_timing_request random_request();
        t_timing_request r;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            r.clock_hz   = 28'($urandom);
            r.nom_rate   = 20'($urandom);
            r.nom_point  = 10'($urandom);
            r.data_rate  = 24'($urandom);
            r.data_point = 10'($urandom);
        end else begin
            r = wellformed_request();
            if (pick == 2) begin
                r.nom_rate = r.nom_rate + 20'd1;
            end else if (pick == 3) begin
                r.data_rate = r.data_rate - 24'd1;
            end
        end
        return r;
    endfunction

    initial begin
        sb = new();
        i_rst_n                  <= 1'b0;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        start                    <= 1'b0;
        i_clock_hz               <= '0;
        i_nominal_rate_bps       <= '0;
        i_nominal_point_permille <= '0;
        i_data_rate_bps          <= '0;
        i_data_point_permille    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests against the reset register values.
        send_request(make_request(80000000, 500000, 875, 2000000, 750));
        send_request(make_request(0, 500000, 875, 2000000, 750));
        send_request(make_request(80000000, 0, 875, 2000000, 750));
        send_request(make_request(80000000, 500000, 875, 0, 750));
        send_request(make_request(80000000, 500000, 0, 2000000, 750));
        send_request(make_request(80000000, 500000, 1000, 2000000, 1000));
        send_request(make_request(80000000, 500000, 1023, 2000000, 1023));
        send_request(make_request(32'h0FFFFFFF, 32'h000FFFFF, 32'h000003FF, 32'h00FFFFFF,
                                  32'h000003FF));
        send_request(make_request(1, 1, 0, 1, 0));
        // Tiny clock: the quantum in picoseconds saturates.
        send_request(make_request(200, 1, 875, 1, 875));
        send_request(make_request(200000000, 1000000, 800, 10000000, 800));
        send_request(make_request(80000000, 500000, 875, 1000, 750));
        send_request(make_request(80000000, 123457, 875, 2000000, 750));
        send_request(make_request(80000000, 125000, 875, 2000000, 750));
        send_request(make_request(40000000, 1000000, 500, 5000000, 600));
        send_request(make_request(24000000, 250000, 700, 1000000, 800));
        send_request(make_request(60000000, 1000000, 667, 8000000, 667));
        send_request(make_request(160000000, 1000000, 900, 10000000, 500));
        send_request(make_request(1, 1000000, 875, 10000000, 875));
        send_request(make_request(200000000, 1, 875, 1, 875));
        send_request(make_request(32'h0FFFFFFF, 1, 500, 1, 500));
        send_request(make_request(100000000, 32'h000FFFFF, 875, 32'h00FFFFFF, 875));

        // Smallest prescaler limits: only a prescaler of one is tried.
        settle();
        configure(2, 1, 256, 128, 2, 1, 32, 16);
        repeat (12) send_request(random_request());

        // Largest prescaler limits with the widest segment bounds.
        settle();
        configure(1024, 1, 256, 128, 64, 1, 32, 16);
        repeat (4) send_request(random_request());

        // Limits above the caps, with the tightest segment maxima.
        settle();
        configure(2047, 1, 1, 1, 127, 1, 1, 1);
        repeat (3) send_request(random_request());

        // Segment minima at their top: nothing can fit.
        settle();
        configure($urandom_range(2, 32), 256, 256, 128, $urandom_range(2, 32), 32, 32, 16);
        repeat (6) send_request(random_request());

        // Random settings, mostly with small prescaler limits.
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            configure($urandom_range(2, 64), skewed(1, 256, 1, 4), skewed(1, 256, 64, 256),
                      skewed(1, 128, 16, 128), $urandom_range(2, 64), skewed(1, 32, 1, 3),
                      skewed(1, 32, 8, 32), skewed(1, 16, 4, 16));
            repeat (12) send_request(random_request());
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- can_fd_bit_timing_search_core.f -----
design/can_bt_pkg.sv
design/can_bt_regs.sv
design/can_bt_div.sv
design/can_fd_bit_timing_search_core.sv
tb/can_fd_bit_timing_search_core_tb.sv
